// ===== rtl/rbnh_pkg.sv =====
// shared types, constants and register codes for the ray box nearest hit block
package rbnh_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = DIFF_W + COORD_W;
	localparam int DIST_W    = 31;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 2;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] RECIP_ONE = COORD_W'(1) <<< FRAC_BITS;

	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RECIP_X   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RECIP_Y   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RECIP_Z   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DIST  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TAG_MASK  = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_min_z;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] box_max_z;
		logic [31:0]               item_id;
		logic [31:0]               item_tag;
		logic                      first_item;
		logic                      last_item;
	} item_t;

	typedef struct packed {
		logic              hit_found;
		logic [DIST_W-1:0] hit_distance;
		logic [31:0]       hit_id;
		logic [31:0]       hit_tag;
	} result_t;

	// what the merge stage hands to the nearest hit keeper
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic              hit;
		logic [DIST_W-1:0] hit_dist;
		logic [31:0]       id;
		logic [31:0]       tag;
	} cand_t;

	// sideband carried along the pipeline next to the lanes
	typedef struct packed {
		logic        tag_ok;
		logic        first;
		logic        last;
		logic [31:0] id;
		logic [31:0] tag;
	} side_t;

endpackage

// ===== rtl/rbnh_lane.sv =====
// one axis lane: corner offsets, slab products, floor shift, saturation and ordering
module rbnh_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [rbnh_pkg::COORD_W-1:0] corner_lo,
	input  logic signed [rbnh_pkg::COORD_W-1:0] corner_hi,
	input  logic signed [rbnh_pkg::COORD_W-1:0] origin,
	input  logic signed [rbnh_pkg::COORD_W-1:0] recip,
	output logic signed [rbnh_pkg::COORD_W-1:0] lo_s3,
	output logic signed [rbnh_pkg::COORD_W-1:0] hi_s3
);

	logic signed [rbnh_pkg::DIFF_W-1:0]  d_a_s1, d_b_s1;
	logic signed [rbnh_pkg::PROD_W-1:0]  p_a_s2, p_b_s2;
	logic signed [rbnh_pkg::PROD_W-1:0]  sh_a, sh_b;
	logic signed [rbnh_pkg::COORD_W-1:0] t_a, t_b;

	function automatic logic signed [rbnh_pkg::COORD_W-1:0] sat32(
		input logic signed [rbnh_pkg::PROD_W-1:0] v
	);
		logic [rbnh_pkg::PROD_W-rbnh_pkg::COORD_W:0] top;
		top = v[rbnh_pkg::PROD_W-1:rbnh_pkg::COORD_W-1];
		if ((&top) || !(|top))
			return v[rbnh_pkg::COORD_W-1:0];
		else if (v[rbnh_pkg::PROD_W-1])
			return rbnh_pkg::T_MIN;
		else
			return rbnh_pkg::T_MAX;
	endfunction

	// arithmetic shift of the exact product rounds toward minus infinity
	assign sh_a = p_a_s2 >>> rbnh_pkg::FRAC_BITS;
	assign sh_b = p_b_s2 >>> rbnh_pkg::FRAC_BITS;
	assign t_a  = sat32(sh_a);
	assign t_b  = sat32(sh_b);

	always_ff @(posedge clk) begin
		if (en) begin
			d_a_s1 <= {corner_lo[rbnh_pkg::COORD_W-1], corner_lo}
				- {origin[rbnh_pkg::COORD_W-1], origin};
			d_b_s1 <= {corner_hi[rbnh_pkg::COORD_W-1], corner_hi}
				- {origin[rbnh_pkg::COORD_W-1], origin};
			p_a_s2 <= {{rbnh_pkg::COORD_W{d_a_s1[rbnh_pkg::DIFF_W-1]}}, d_a_s1}
				* {{rbnh_pkg::DIFF_W{recip[rbnh_pkg::COORD_W-1]}}, recip};
			p_b_s2 <= {{rbnh_pkg::COORD_W{d_b_s1[rbnh_pkg::DIFF_W-1]}}, d_b_s1}
				* {{rbnh_pkg::DIFF_W{recip[rbnh_pkg::COORD_W-1]}}, recip};
			if (t_a < t_b) begin
				lo_s3 <= t_a;
				hi_s3 <= t_b;
			end else begin
				lo_s3 <= t_b;
				hi_s3 <= t_a;
			end
		end
	end

endmodule

// ===== rtl/rbnh_merge.sv =====
// merges the three lanes into entry/exit distances and a hit decision
module rbnh_merge (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [rbnh_pkg::COORD_W-1:0] lo_x,
	input  logic signed [rbnh_pkg::COORD_W-1:0] lo_y,
	input  logic signed [rbnh_pkg::COORD_W-1:0] lo_z,
	input  logic signed [rbnh_pkg::COORD_W-1:0] hi_x,
	input  logic signed [rbnh_pkg::COORD_W-1:0] hi_y,
	input  logic signed [rbnh_pkg::COORD_W-1:0] hi_z,
	input  logic [rbnh_pkg::DIST_W-1:0]         max_distance,
	output logic                                hit_s5,
	output logic [rbnh_pkg::DIST_W-1:0]         dist_s5
);

	logic signed [rbnh_pkg::COORD_W-1:0] lo_xy, hi_xy, tmin, tmax;
	logic signed [rbnh_pkg::COORD_W-1:0] tmin_s4, tmax_s4;
	logic [rbnh_pkg::DIST_W-1:0]         t;
	logic                                slab_hit;

	always_comb begin
		lo_xy = (lo_x > lo_y) ? lo_x : lo_y;
		tmin  = (lo_xy > lo_z) ? lo_xy : lo_z;
		hi_xy = (hi_x < hi_y) ? hi_x : hi_y;
		tmax  = (hi_xy < hi_z) ? hi_xy : hi_z;
	end

	// ray starting inside the box clamps the entry distance to zero
	always_comb begin
		slab_hit = !tmax_s4[rbnh_pkg::COORD_W-1] && !(tmin_s4 > tmax_s4);
		t        = tmin_s4[rbnh_pkg::COORD_W-1] ? '0 : tmin_s4[rbnh_pkg::DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s4 <= tmin;
			tmax_s4 <= tmax;
			hit_s5  <= slab_hit && (t <= max_distance);
			dist_s5 <= t;
		end
	end

endmodule

// ===== rtl/rbnh_best.sv =====
// keeps the nearest hit over a run of items and holds the result register
module rbnh_best (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rbnh_pkg::cand_t   cand,
	output logic              result_valid,
	input  logic              result_stall,
	output rbnh_pkg::result_t result
);

	logic                        best_valid_q;
	logic [rbnh_pkg::DIST_W-1:0] best_dist_q;
	logic [31:0]                 best_id_q, best_tag_q;

	logic                        base_valid, upd, take;
	logic [rbnh_pkg::DIST_W-1:0] base_dist;
	logic [31:0]                 base_id, base_tag;
	rbnh_pkg::result_t           next_best;

	assign take = en && cand.valid;

	always_comb begin
		if (cand.first) begin
			base_valid = 1'b0;
			base_dist  = rbnh_pkg::DIST_MAX;
			base_id    = '0;
			base_tag   = '0;
		end else begin
			base_valid = best_valid_q;
			base_dist  = best_dist_q;
			base_id    = best_id_q;
			base_tag   = best_tag_q;
		end
		// on a tie the earlier item stays
		upd = cand.hit && !(base_valid && (cand.hit_dist >= base_dist));
		if (upd) begin
			next_best.hit_found    = 1'b1;
			next_best.hit_distance = cand.hit_dist;
			next_best.hit_id       = cand.id;
			next_best.hit_tag      = cand.tag;
		end else begin
			next_best.hit_found    = base_valid;
			next_best.hit_distance = base_dist;
			next_best.hit_id       = base_id;
			next_best.hit_tag      = base_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_dist_q  <= rbnh_pkg::DIST_MAX;
			best_id_q    <= '0;
			best_tag_q   <= '0;
		end else if (take) begin
			best_valid_q <= next_best.hit_found;
			best_dist_q  <= next_best.hit_distance;
			best_id_q    <= next_best.hit_id;
			best_tag_q   <= next_best.hit_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take && cand.last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cand.last) begin
			result <= next_best;
		end
	end

endmodule

// ===== rtl/ray_box_nearest_hit_top.sv =====
// top level of the ray box nearest hit block: config registers, pipeline control, lanes
//
// Boxes arrive on the item channel (item_valid, item_stall, item); one is taken at every
// rising edge with item_valid high and item_stall low. Three axis lanes run the slab test
// side by side, a merge stage forms the entry/exit distances, and a keeper stage holds
// the nearest hit of the current run. first_item clears the kept hit before the box is
// tested; last_item makes the block deliver one transaction on the result channel.
// Throughput is one box per cycle while item_stall is low: each lane has its own two
// multipliers, so nothing is shared between items. The result of a last item passes
// the subtract, multiply, shift/saturate, merge, hit test and keeper registers in turn.
// The result register lets items without last_item keep flowing while a result
// waits; only a last item that reaches the keeper while the result is still stalled
// holds the whole pipeline, and item_stall rises for that time. Reset clears the kept
// hit, empties the pipeline and loads the register defaults (origin zero, reciprocal
// direction one, no distance limit, no tag filter). Registers sit on the APB port at
// 4-byte spacing; the user must write them only while idle, the block does not check it.
module ray_box_nearest_hit_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  rbnh_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output rbnh_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbnh_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic signed [rbnh_pkg::COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [rbnh_pkg::COORD_W-1:0] recip_x_q, recip_y_q, recip_z_q;
	logic [rbnh_pkg::DIST_W-1:0]         max_dist_q;
	logic [31:0]                         tag_mask_q;

	logic [rbnh_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           cfg_wr;

	logic           en, accept;
	logic           valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	rbnh_pkg::side_t side_in, side_s1, side_s2, side_s3, side_s4, side_s5;
	rbnh_pkg::cand_t cand;

	logic signed [rbnh_pkg::COORD_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic                                hit_s5;
	logic [rbnh_pkg::DIST_W-1:0]         dist_s5;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[rbnh_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			recip_x_q  <= rbnh_pkg::RECIP_ONE;
			recip_y_q  <= rbnh_pkg::RECIP_ONE;
			recip_z_q  <= rbnh_pkg::RECIP_ONE;
			max_dist_q <= rbnh_pkg::DIST_MAX;
			tag_mask_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				rbnh_pkg::REG_ORIGIN_X: origin_x_q <= pwdata;
				rbnh_pkg::REG_ORIGIN_Y: origin_y_q <= pwdata;
				rbnh_pkg::REG_ORIGIN_Z: origin_z_q <= pwdata;
				rbnh_pkg::REG_RECIP_X:  recip_x_q  <= pwdata;
				rbnh_pkg::REG_RECIP_Y:  recip_y_q  <= pwdata;
				rbnh_pkg::REG_RECIP_Z:  recip_z_q  <= pwdata;
				rbnh_pkg::REG_MAX_DIST: max_dist_q <= pwdata[rbnh_pkg::DIST_W-1:0];
				rbnh_pkg::REG_TAG_MASK: tag_mask_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rbnh_pkg::REG_ORIGIN_X: prdata = origin_x_q;
			rbnh_pkg::REG_ORIGIN_Y: prdata = origin_y_q;
			rbnh_pkg::REG_ORIGIN_Z: prdata = origin_z_q;
			rbnh_pkg::REG_RECIP_X:  prdata = recip_x_q;
			rbnh_pkg::REG_RECIP_Y:  prdata = recip_y_q;
			rbnh_pkg::REG_RECIP_Z:  prdata = recip_z_q;
			rbnh_pkg::REG_MAX_DIST: prdata = {1'b0, max_dist_q};
			rbnh_pkg::REG_TAG_MASK: prdata = tag_mask_q;
			default:                prdata = '0;
		endcase
	end

	// pipeline moves unless a last item would overwrite a stalled result
	assign en         = !(valid_s5 && side_s5.last && result_valid && result_stall);
	assign item_stall = !en;
	assign accept     = item_valid && en;

	always_comb begin
		side_in.tag_ok = (tag_mask_q == '0) || ((item.item_tag & tag_mask_q) != '0);
		side_in.first  = item.first_item;
		side_in.last   = item.last_item;
		side_in.id     = item.item_id;
		side_in.tag    = item.item_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	rbnh_lane u_lane_x (
		.clk       (clk),
		.en        (en),
		.corner_lo (item.box_min_x),
		.corner_hi (item.box_max_x),
		.origin    (origin_x_q),
		.recip     (recip_x_q),
		.lo_s3     (lo_x),
		.hi_s3     (hi_x)
	);

	rbnh_lane u_lane_y (
		.clk       (clk),
		.en        (en),
		.corner_lo (item.box_min_y),
		.corner_hi (item.box_max_y),
		.origin    (origin_y_q),
		.recip     (recip_y_q),
		.lo_s3     (lo_y),
		.hi_s3     (hi_y)
	);

	rbnh_lane u_lane_z (
		.clk       (clk),
		.en        (en),
		.corner_lo (item.box_min_z),
		.corner_hi (item.box_max_z),
		.origin    (origin_z_q),
		.recip     (recip_z_q),
		.lo_s3     (lo_z),
		.hi_s3     (hi_z)
	);

	rbnh_merge u_merge (
		.clk          (clk),
		.en           (en),
		.lo_x         (lo_x),
		.lo_y         (lo_y),
		.lo_z         (lo_z),
		.hi_x         (hi_x),
		.hi_y         (hi_y),
		.hi_z         (hi_z),
		.max_distance (max_dist_q),
		.hit_s5       (hit_s5),
		.dist_s5      (dist_s5)
	);

	always_comb begin
		cand.valid    = valid_s5;
		cand.first    = side_s5.first;
		cand.last     = side_s5.last;
		cand.hit      = hit_s5 && side_s5.tag_ok;
		cand.hit_dist = dist_s5;
		cand.id       = side_s5.id;
		cand.tag      = side_s5.tag;
	end

	rbnh_best u_best (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cand         (cand),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== dv/ray_box_nearest_hit_checker.sv =====
`timescale 1ns / 1ps
// checker for the ray box nearest hit block: tracks the ray registers, predicts and compares
module ray_box_nearest_hit_checker
	import rbnh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  item_t               item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  result_t             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending
);

	longint ray_org[3];
	longint ray_recip[3];
	logic [DIST_W-1:0] dist_limit;
	logic [31:0] tag_filter;

	logic kept_valid;
	logic [DIST_W-1:0] kept_dist;
	logic [31:0] kept_id;
	logic [31:0] kept_tag;

	result_t expected_hits[$];

	// (corner - origin) * recip, floor shift, clamped to the signed 32 bit range
	function automatic longint slab_param(longint corner, longint org, longint recip);
		longint t;
		t = ((corner - org) * recip) >>> FRAC_BITS;
		if (t > longint'(T_MAX))
			return longint'(T_MAX);
		if (t < longint'(T_MIN))
			return longint'(T_MIN);
		return t;
	endfunction

	task automatic trace_box(input item_t it);
		longint lo[3];
		longint hi[3];
		longint a;
		longint b;
		longint tmin;
		longint tmax;
		logic [DIST_W-1:0] t;
		result_t hit;
		if (it.first_item) begin
			kept_valid = 1'b0;
			kept_dist  = DIST_MAX;
			kept_id    = '0;
			kept_tag   = '0;
		end
		if (tag_filter == '0 || (it.item_tag & tag_filter) != '0) begin
			lo[0] = $signed(it.box_min_x);
			lo[1] = $signed(it.box_min_y);
			lo[2] = $signed(it.box_min_z);
			hi[0] = $signed(it.box_max_x);
			hi[1] = $signed(it.box_max_y);
			hi[2] = $signed(it.box_max_z);
			tmin = longint'(T_MIN);
			tmax = longint'(T_MAX);
			for (int ax = 0; ax < 3; ax++) begin
				a = slab_param(lo[ax], ray_org[ax], ray_recip[ax]);
				b = slab_param(hi[ax], ray_org[ax], ray_recip[ax]);
				// inverted corners just swap the slab ends
				if (a > b) begin
					tmin = (b > tmin) ? b : tmin;
					tmax = (a < tmax) ? a : tmax;
				end else begin
					tmin = (a > tmin) ? a : tmin;
					tmax = (b < tmax) ? b : tmax;
				end
			end
			if (!(tmax < 0 || tmin > tmax)) begin
				t = (tmin > 0) ? tmin[DIST_W-1:0] : '0;
				// equal distance keeps the earlier box
				if (t <= dist_limit && !(kept_valid && t >= kept_dist)) begin
					kept_valid = 1'b1;
					kept_dist  = t;
					kept_id    = it.item_id;
					kept_tag   = it.item_tag;
				end
			end
		end
		if (it.last_item) begin
			hit.hit_found    = kept_valid;
			hit.hit_distance = kept_dist;
			hit.hit_id       = kept_id;
			hit.hit_tag      = kept_tag;
			expected_hits.push_back(hit);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int ax = 0; ax < 3; ax++) begin
				ray_org[ax]   = 0;
				ray_recip[ax] = longint'(RECIP_ONE);
			end
			dist_limit = DIST_MAX;
			tag_filter = '0;
			kept_valid = 1'b0;
			kept_dist  = DIST_MAX;
			kept_id    = '0;
			kept_tag   = '0;
			expected_hits.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ORIGIN_X: ray_org[0] = $signed(pwdata);
					REG_ORIGIN_Y: ray_org[1] = $signed(pwdata);
					REG_ORIGIN_Z: ray_org[2] = $signed(pwdata);
					REG_RECIP_X:  ray_recip[0] = $signed(pwdata);
					REG_RECIP_Y:  ray_recip[1] = $signed(pwdata);
					REG_RECIP_Z:  ray_recip[2] = $signed(pwdata);
					REG_MAX_DIST: dist_limit = pwdata[DIST_W-1:0];
					REG_TAG_MASK: tag_filter = pwdata;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_hits.size() == 0) begin
					$error("result transaction with no expected result");
					fail_count++;
				end else begin
					want = expected_hits.pop_front();
					if (result.hit_found !== want.hit_found) begin
						$error("hit_found: expected %0d, actual %0d",
							want.hit_found, result.hit_found);
						fail_count++;
					end
					if (result.hit_distance !== want.hit_distance) begin
						$error("hit_distance: expected %h, actual %h",
							want.hit_distance, result.hit_distance);
						fail_count++;
					end
					if (result.hit_id !== want.hit_id) begin
						$error("hit_id: expected %h, actual %h", want.hit_id, result.hit_id);
						fail_count++;
					end
					if (result.hit_tag !== want.hit_tag) begin
						$error("hit_tag: expected %h, actual %h", want.hit_tag, result.hit_tag);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				trace_box(item);
			pending = expected_hits.size();
		end
	end

endmodule

// ===== dv/ray_box_nearest_hit_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the ray box nearest hit block: stimulus, register writes and verdict
module ray_box_nearest_hit_top_tb;
	import rbnh_pkg::*;

	localparam int ONE          = 1 << FRAC_BITS;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 150;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	item_t             item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	// current ray, kept here to aim boxes along it
	longint ray_org[3];
	longint ray_dir[3];
	logic [31:0] cur_mask = '0;

	always #4 clk = ~clk;

	ray_box_nearest_hit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	ray_box_nearest_hit_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side back-pressure, one draw per transaction
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = quiet ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				result_stall = 1'b1;
				repeat (n) @(negedge clk);
				result_stall = 1'b0;
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	function automatic item_t box_item(int lx, int ly, int lz, int hx, int hy, int hz,
			logic [31:0] id, logic [31:0] tag, bit first, bit last);
		item_t it;
		it.box_min_x  = lx;
		it.box_min_y  = ly;
		it.box_min_z  = lz;
		it.box_max_x  = hx;
		it.box_max_y  = hy;
		it.box_max_z  = hz;
		it.item_id    = id;
		it.item_tag   = tag;
		it.first_item = first;
		it.last_item  = last;
		return it;
	endfunction

	function automatic logic [31:0] near_coord();
		return int'($urandom_range(0, 64 << 16)) - (32 << 16);
	endfunction

	function automatic logic [31:0] nice_recip();
		case ($urandom_range(0, 6))
			0: return ONE;
			1: return -ONE;
			2: return 2 * ONE;
			3: return -2 * ONE;
			4: return ONE / 2;
			5: return -ONE / 2;
			default: return 4 * ONE;
		endcase
	endfunction

	function automatic logic [31:0] wild_recip();
		case ($urandom_range(0, 5))
			0: return T_MAX;
			1: return T_MIN;
			2: return '0;
			3: return 32'd1;
			4: return '1;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_box(input item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (!(item_valid && !item_stall));
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		item_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// boxes without last_item may still be in flight once nothing is pending
	task automatic settle();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic program_ray(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] oz, input logic [31:0] rx, input logic [31:0] ry,
			input logic [31:0] rz, input logic [DIST_W-1:0] limit, input logic [31:0] mask);
		longint r[3];
		settle();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_RECIP_X, rx);
		write_reg(REG_RECIP_Y, ry);
		write_reg(REG_RECIP_Z, rz);
		write_reg(REG_MAX_DIST, {1'b0, limit});
		write_reg(REG_TAG_MASK, mask);
		ray_org[0] = $signed(ox);
		ray_org[1] = $signed(oy);
		ray_org[2] = $signed(oz);
		r[0] = $signed(rx);
		r[1] = $signed(ry);
		r[2] = $signed(rz);
		for (int ax = 0; ax < 3; ax++)
			ray_dir[ax] = (r[ax] == 0) ? 0 : (longint'(1) <<< 32) / r[ax];
		cur_mask = mask;
	endtask

	initial begin
		item_t it;
		item_t prev;
		longint lo[3];
		longint hi[3];
		longint c;
		longint reach;
		longint swap;
		logic [DIST_W-1:0] limit;
		logic [31:0] mask;
		logic [31:0] tag;
		int sent;
		int run_len;
		int roll;
		bit broken;
		bit drained;

		for (int ax = 0; ax < 3; ax++) begin
			ray_org[ax] = 0;
			ray_dir[ax] = ONE;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed boxes on the default ray: origin zero, direction one
		send_box(box_item(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, '1, '1, 1, 1));
		send_box(box_item(5 * ONE, 5 * ONE, 5 * ONE, 6 * ONE, 6 * ONE, 6 * ONE, 1, 1, 1, 0));
		send_box(box_item(3 * ONE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 2, 2, 0, 0));
		// same distance again, the earlier box stays
		send_box(box_item(3 * ONE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 3, 3, 0, 0));
		send_box(box_item(-4 * ONE, -4 * ONE, -4 * ONE, -3 * ONE, -3 * ONE, -3 * ONE,
			4, 4, 0, 1));
		// origin inside the box
		send_box(box_item(-ONE, -ONE, -ONE, ONE, ONE, ONE, 5, 5, 1, 1));
		// inverted corners
		send_box(box_item(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE, 6, 6, 1, 1));
		send_box(box_item(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, 7, 0, 1, 1));
		send_box(box_item(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, 8, '1, 1, 1));
		// behind the ray, nothing kept at emission
		send_box(box_item(-4 * ONE, -4 * ONE, -4 * ONE, -3 * ONE, -3 * ONE, -3 * ONE,
			9, 9, 1, 1));
		// kept hit carries over when first_item is missing
		send_box(box_item(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 10, 10, 1, 0));
		send_box(box_item(7 * ONE, 7 * ONE, 7 * ONE, 8 * ONE, 8 * ONE, 8 * ONE, 11, 11, 0, 1));
		send_box(box_item(9 * ONE, 9 * ONE, 9 * ONE, 19 * ONE / 2, 19 * ONE / 2, 19 * ONE / 2,
			12, 12, 0, 1));
		// flat slab, entry equals exit
		send_box(box_item(3 * ONE, 0, 0, 3 * ONE, 5 * ONE, 5 * ONE, 13, 13, 1, 1));

		settle();
		write_reg(REG_TAG_MASK, 32'h0000_000f);
		write_reg(REG_MAX_DIST, 2 * ONE);
		// beyond the distance limit
		send_box(box_item(3 * ONE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 14, 1, 1, 1));
		// exactly at the limit is kept
		send_box(box_item(2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, 15, 1, 1, 0));
		// nearer boxes filtered out by tag
		send_box(box_item(ONE / 2, ONE / 2, ONE / 2, ONE, ONE, ONE, 16, 32'h10, 0, 0));
		send_box(box_item(3 * ONE / 2, 3 * ONE / 2, 3 * ONE / 2, 2 * ONE, 2 * ONE, 2 * ONE,
			17, 0, 0, 1));

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0, 1: limit = DIST_MAX;
				2: limit = '0;
				default: limit = $urandom_range(ONE, 64 * ONE);
			endcase
			case ($urandom_range(0, 3))
				0, 1: mask = '0;
				2: mask = $urandom;
				default: mask = 32'h1 << $urandom_range(0, 31);
			endcase
			case (ph)
				2: program_ray(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, DIST_MAX, '1);
				5: program_ray(T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN, '0, '0);
				8: program_ray($urandom, $urandom, $urandom, wild_recip(), wild_recip(),
					wild_recip(), $urandom, $urandom);
				default: program_ray(near_coord(), near_coord(), near_coord(), nice_recip(),
					nice_recip(), nice_recip(), limit, mask);
			endcase

			sent = 0;
			drained = 1'b0;
			prev = item;
			while (sent < PHASE_ITEMS) begin
				if (!drained && sent >= PHASE_ITEMS / 2) begin
					hold_until_drained();
					drained = 1'b1;
				end
				quiet = ($urandom_range(0, 4) == 0);
				run_len = $urandom_range(1, 12);
				broken = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < run_len; k++) begin
					roll = $urandom_range(0, 99);
					reach = $urandom_range(0, 48 * ONE);
					for (int ax = 0; ax < 3; ax++) begin
						if (roll < 65) begin
							// a box around one point of the ray
							c = ray_org[ax] + ((reach * ray_dir[ax]) >>> FRAC_BITS);
							lo[ax] = c - $urandom_range(0, 4 * ONE);
							hi[ax] = c + $urandom_range(0, 4 * ONE);
						end else if (roll < 80) begin
							lo[ax] = longint'($urandom_range(0, 128 * ONE)) - 64 * ONE;
							hi[ax] = lo[ax] + $urandom_range(0, 16 * ONE);
						end else begin
							lo[ax] = $urandom;
							hi[ax] = $urandom;
						end
					end
					if (roll >= 55 && roll < 65) begin
						swap = lo[0];
						lo[0] = hi[0];
						hi[0] = swap;
					end
					case ($urandom_range(0, 2))
						0: tag = $urandom & cur_mask;
						1: tag = $urandom;
						default: tag = $urandom & ~cur_mask;
					endcase
					it = box_item(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom, tag,
						k == 0, k == run_len - 1);
					// repeat of the previous box, same distance
					if (roll >= 92) begin
						it.box_min_x = prev.box_min_x;
						it.box_min_y = prev.box_min_y;
						it.box_min_z = prev.box_min_z;
						it.box_max_x = prev.box_max_x;
						it.box_max_y = prev.box_max_y;
						it.box_max_z = prev.box_max_z;
					end
					if (broken) begin
						it.first_item = $urandom_range(0, 1);
						it.last_item  = $urandom_range(0, 1);
					end
					send_box(it);
					prev = it;
					sent++;
				end
			end
		end

		quiet = 1'b0;
		settle();
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
